// File: sv/bafc_pkg.sv
package bafc_pkg;

	// Default internal data width (signed Q.8 values)
	localparam int DATA_WIDTH = 32;

	// Fixed field and register widths
	localparam int FIELD_W     = 32;
	localparam int PERIOD_W    = 10;
	localparam int GAIN_W      = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_ACC = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_VEL = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_POS = 2'd3;

	// Register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RST   = 10'd5;
	localparam logic [GAIN_W-1:0]   GAIN_ACC_RST = 16'd4194;
	localparam logic [GAIN_W-1:0]   GAIN_VEL_RST = 16'd31457;
	localparam logic [GAIN_W-1:0]   GAIN_POS_RST = 16'd52429;

	// Divisors: gain terms divide by 2^16 * 1000, step terms by 2 * 1000
	localparam int DEN_W = 26;
	localparam logic [DEN_W-1:0] GAIN_DEN = 26'd65536000;
	localparam logic [DEN_W-1:0] DT_DEN   = 26'd2000;

	typedef struct packed {
		logic signed [FIELD_W-1:0] baro_altitude;
		logic signed [FIELD_W-1:0] vertical_accel;
	} sample_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] fused_altitude;
		logic signed [FIELD_W-1:0] fused_speed;
		logic signed [FIELD_W-1:0] fused_accel;
	} estimate_t;

	// Scaling operations, in the order they run for one sample
	typedef enum logic [2:0] {
		OP_ACC = 3'd0,
		OP_VEL = 3'd1,
		OP_POS = 3'd2,
		OP_DV  = 3'd3,
		OP_HGT = 3'd4
	} op_t;

	typedef struct packed {
		logic load_in;
		logic calc_err;
		logic load_op;
		logic abs_op;
		logic mul_gain;
		logic mul_period;
		logic div_init;
		logic div_step;
		logic finish;
		logic apply;
		logic est_acc;
		logic update;
		logic out_load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} status_t;

endpackage

// File: sv/bafc_chan_if.sv
interface bafc_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: sv/bafc_ctrl.sv
module bafc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output bafc_pkg::cmd_t    cmd,
	input  bafc_pkg::status_t stat
);

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_ERR     = 13'b0000000000010,
		ST_LOAD    = 13'b0000000000100,
		ST_ABS     = 13'b0000000001000,
		ST_MUL1    = 13'b0000000010000,
		ST_MUL2    = 13'b0000000100000,
		ST_DINIT   = 13'b0000001000000,
		ST_DIV     = 13'b0000010000000,
		ST_FIN     = 13'b0000100000000,
		ST_APPLY   = 13'b0001000000000,
		ST_EST_ACC = 13'b0010000000000,
		ST_UPD     = 13'b0100000000000,
		ST_OUT     = 13'b1000000000000
	} state_t;

	state_t         state_q, state_d;
	bafc_pkg::op_t  op_q, op_d;
	logic           ov_q;
	logic           out_free;

	assign out_free  = !ov_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ov_q;

	// Next state and operation sequencing
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_ERR;
			end
			ST_ERR: begin
				op_d    = bafc_pkg::OP_ACC;
				state_d = ST_LOAD;
			end
			ST_LOAD:  state_d = ST_ABS;
			ST_ABS:   state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_DINIT;
			ST_DINIT: state_d = ST_DIV;
			ST_DIV: begin
				if (stat.div_last) state_d = ST_FIN;
			end
			ST_FIN:   state_d = ST_APPLY;
			ST_APPLY: begin
				unique case (op_q)
					bafc_pkg::OP_ACC: begin
						op_d    = bafc_pkg::OP_VEL;
						state_d = ST_LOAD;
					end
					bafc_pkg::OP_VEL: begin
						op_d    = bafc_pkg::OP_POS;
						state_d = ST_LOAD;
					end
					bafc_pkg::OP_POS: state_d = ST_EST_ACC;
					bafc_pkg::OP_DV: begin
						op_d    = bafc_pkg::OP_HGT;
						state_d = ST_LOAD;
					end
					bafc_pkg::OP_HGT: state_d = ST_UPD;
					default:          state_d = ST_UPD;
				endcase
			end
			ST_EST_ACC: begin
				op_d    = bafc_pkg::OP_DV;
				state_d = ST_LOAD;
			end
			ST_UPD: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.load_in    = (state_q == ST_IDLE) && in_valid;
		cmd.calc_err   = (state_q == ST_ERR);
		cmd.load_op    = (state_q == ST_LOAD);
		cmd.abs_op     = (state_q == ST_ABS);
		cmd.mul_gain   = (state_q == ST_MUL1);
		cmd.mul_period = (state_q == ST_MUL2);
		cmd.div_init   = (state_q == ST_DINIT);
		cmd.div_step   = (state_q == ST_DIV);
		cmd.finish     = (state_q == ST_FIN);
		cmd.apply      = (state_q == ST_APPLY);
		cmd.est_acc    = (state_q == ST_EST_ACC);
		cmd.update     = (state_q == ST_UPD);
		cmd.out_load   = (state_q == ST_OUT) && out_free;
		cmd.op         = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= bafc_pkg::OP_ACC;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	// A pending result beat is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && ov_q) |-> out_ready)
		else $error("result overwritten while pending");

	// One sample at a time: no accept right after an accept
	a_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second sample accepted while busy");

endmodule

// File: sv/bafc_dp.sv
module bafc_dp #(
	parameter int DATA_WIDTH = bafc_pkg::DATA_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [bafc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [bafc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  bafc_pkg::cmd_t                       cmd,
	output bafc_pkg::status_t                    stat,
	input  bafc_pkg::sample_t                    sample_data,
	output bafc_pkg::estimate_t                  estimate_data
);

	localparam int DW    = DATA_WIDTH;
	localparam int OW    = DW + 2;                       // scaling operand
	localparam int MW    = DW + 1;                       // operand magnitude
	localparam int PW    = MW + bafc_pkg::GAIN_W;        // after gain multiply
	localparam int NW    = PW + bafc_pkg::PERIOD_W;      // dividend
	localparam int QW    = DW + (DW % 2);                // quotient bits, even
	localparam int SCW   = $clog2(QW / 2);
	localparam int TW    = bafc_pkg::DEN_W + 2;
	localparam int FW    = bafc_pkg::FIELD_W;
	localparam int SW    = ((DW > FW) ? DW : FW) + 3;    // wide signed sums

	// Saturate a wide signed value to the data range
	function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] x);
		logic [SW-DW:0] hi;
		hi = x[SW-1:DW-1];
		if ((&hi) || !(|hi)) return x[DW-1:0];
		else if (x[SW-1]) return {1'b1, {(DW-1){1'b0}}};
		else return {1'b0, {(DW-1){1'b1}}};
	endfunction

	// Saturate a data value to the output field range
	function automatic logic signed [FW-1:0] to_field(input logic signed [DW-1:0] v);
		logic signed [SW-1:0] x;
		logic [SW-FW:0]       hi;
		x  = SW'(v);
		hi = x[SW-1:FW-1];
		if ((&hi) || !(|hi)) return x[FW-1:0];
		else if (x[SW-1]) return {1'b1, {(FW-1){1'b0}}};
		else return {1'b0, {(FW-1){1'b1}}};
	endfunction

	// Configuration
	logic [bafc_pkg::PERIOD_W-1:0] period_q;
	logic [bafc_pkg::GAIN_W-1:0]   gain_acc_q, gain_vel_q, gain_pos_q;

	// Filter state
	logic signed [DW-1:0] acc_corr_q, spd_corr_q, hgt_corr_q;
	logic signed [DW-1:0] raw_spd_q, raw_hgt_q;
	logic signed [DW-1:0] est_hgt_q, est_spd_q, est_acc_q;

	// Per-sample working registers
	logic signed [DW-1:0] baro_q, accel_in_q, err_q, prev_acc_q, dv_q, scaled_q;
	logic signed [OW-1:0] operand_q;
	logic                 neg_q;
	logic [MW-1:0]        mag_q;
	logic [PW-1:0]        prod_q;
	logic [NW-1:0]        num_q;
	logic [QW-1:0]        quo_q;
	logic [bafc_pkg::DEN_W-1:0] rem_q;
	logic [SCW-1:0]       step_q;
	bafc_pkg::estimate_t  out_q;

	// Operation dependent multiplier and divisor
	logic                        gain_op;
	logic [bafc_pkg::GAIN_W-1:0] mul_c;
	logic [bafc_pkg::DEN_W-1:0]  den_c;
	logic signed [OW-1:0]        operand_c;
	logic signed [OW-1:0]        negated_c;
	logic signed [SW-1:0]        quo_s_c;
	logic [TW-1:0]               t_c, d1_c, d2_c, d3_c;
	logic [1:0]                  digit_c;
	logic [TW-1:0]               t_rem_c;

	assign gain_op = (cmd.op == bafc_pkg::OP_ACC) || (cmd.op == bafc_pkg::OP_VEL)
		|| (cmd.op == bafc_pkg::OP_POS);
	assign den_c   = gain_op ? bafc_pkg::GAIN_DEN : bafc_pkg::DT_DEN;

	always_comb begin
		unique case (cmd.op)
			bafc_pkg::OP_ACC: mul_c = gain_acc_q;
			bafc_pkg::OP_VEL: mul_c = gain_vel_q;
			bafc_pkg::OP_POS: mul_c = gain_pos_q;
			default:          mul_c = bafc_pkg::GAIN_W'(1);
		endcase
	end

	// Operand of the next scaling
	always_comb begin
		unique case (cmd.op)
			bafc_pkg::OP_DV:  operand_c = OW'(prev_acc_q) + OW'(est_acc_q);
			bafc_pkg::OP_HGT: operand_c = (OW'(est_spd_q) <<< 1) + OW'(dv_q);
			default:          operand_c = OW'(err_q);
		endcase
	end

	assign negated_c = -operand_q;

	// Radix-4 restoring divide step
	always_comb begin
		t_c  = {rem_q, quo_q[QW-1 -: 2]};
		d1_c = TW'(den_c);
		d2_c = d1_c << 1;
		d3_c = d1_c + d2_c;
		priority if (t_c >= d3_c) begin
			digit_c = 2'd3;
			t_rem_c = t_c - d3_c;
		end else if (t_c >= d2_c) begin
			digit_c = 2'd2;
			t_rem_c = t_c - d2_c;
		end else if (t_c >= d1_c) begin
			digit_c = 2'd1;
			t_rem_c = t_c - d1_c;
		end else begin
			digit_c = 2'd0;
			t_rem_c = t_c;
		end
	end

	// Signed quotient
	always_comb begin
		quo_s_c = SW'(quo_q);
		if (neg_q) quo_s_c = -quo_s_c;
	end

	assign stat.div_last = (step_q == '0);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= bafc_pkg::PERIOD_RST;
			gain_acc_q <= bafc_pkg::GAIN_ACC_RST;
			gain_vel_q <= bafc_pkg::GAIN_VEL_RST;
			gain_pos_q <= bafc_pkg::GAIN_POS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bafc_pkg::REG_PERIOD:   period_q   <= cfg_data[bafc_pkg::PERIOD_W-1:0];
				bafc_pkg::REG_GAIN_ACC: gain_acc_q <= cfg_data;
				bafc_pkg::REG_GAIN_VEL: gain_vel_q <= cfg_data;
				bafc_pkg::REG_GAIN_POS: gain_pos_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Filter state and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_corr_q <= '0;
			spd_corr_q <= '0;
			hgt_corr_q <= '0;
			raw_spd_q  <= '0;
			raw_hgt_q  <= '0;
			est_hgt_q  <= '0;
			est_spd_q  <= '0;
			est_acc_q  <= '0;
			step_q     <= '0;
		end else begin
			if (cmd.div_init) step_q <= SCW'(QW / 2 - 1);
			else if (cmd.div_step && (step_q != '0)) step_q <= step_q - 1'b1;

			if (cmd.apply) begin
				unique case (cmd.op)
					bafc_pkg::OP_ACC:
						acc_corr_q <= sat_dw(SW'(acc_corr_q) + SW'(scaled_q));
					bafc_pkg::OP_VEL:
						spd_corr_q <= sat_dw(SW'(spd_corr_q) + SW'(scaled_q));
					bafc_pkg::OP_POS:
						hgt_corr_q <= sat_dw(SW'(hgt_corr_q) + SW'(scaled_q));
					bafc_pkg::OP_HGT: begin
						raw_hgt_q <= sat_dw(SW'(raw_hgt_q) + SW'(scaled_q));
						raw_spd_q <= sat_dw(SW'(raw_spd_q) + SW'(dv_q));
					end
					default: ;
				endcase
			end

			if (cmd.est_acc)
				est_acc_q <= sat_dw(SW'(accel_in_q) + SW'(acc_corr_q));

			if (cmd.update) begin
				est_hgt_q <= sat_dw(SW'(raw_hgt_q) + SW'(hgt_corr_q));
				est_spd_q <= sat_dw(SW'(raw_spd_q) + SW'(spd_corr_q));
			end
		end
	end

	// Working registers and scaling unit
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			baro_q     <= sat_dw(SW'(sample_data.baro_altitude));
			accel_in_q <= sat_dw(SW'(sample_data.vertical_accel));
		end
		if (cmd.calc_err) err_q <= sat_dw(SW'(baro_q) - SW'(est_hgt_q));
		if (cmd.load_op) operand_q <= operand_c;
		if (cmd.abs_op) begin
			neg_q <= operand_q[OW-1];
			mag_q <= operand_q[OW-1] ? negated_c[MW-1:0] : operand_q[MW-1:0];
		end
		if (cmd.mul_gain) prod_q <= PW'(mag_q) * PW'(mul_c);
		if (cmd.mul_period)
			num_q <= NW'(prod_q) * NW'(period_q) + NW'(den_c >> 1);
		if (cmd.div_init) begin
			rem_q <= num_q[QW +: bafc_pkg::DEN_W];
			quo_q <= num_q[QW-1:0];
		end else if (cmd.div_step) begin
			rem_q <= t_rem_c[bafc_pkg::DEN_W-1:0];
			quo_q <= {quo_q[QW-3:0], digit_c};
		end
		if (cmd.finish) scaled_q <= sat_dw(quo_s_c);
		if (cmd.est_acc) prev_acc_q <= est_acc_q;
		if (cmd.apply && (cmd.op == bafc_pkg::OP_DV)) dv_q <= scaled_q;
		if (cmd.out_load) begin
			out_q.fused_altitude <= to_field(est_hgt_q);
			out_q.fused_speed    <= to_field(est_spd_q);
			out_q.fused_accel    <= to_field(est_acc_q);
		end
	end

	assign estimate_data = out_q;

	// Remainder stays below the divisor while dividing
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < den_c))
		else $error("divider remainder out of range");

	// Zero step gives a zero scaled term
	a_zero_period: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && (period_q == '0)) |=> (scaled_q == '0))
		else $error("nonzero scaled term with zero period");

endmodule

// File: sv/baro_accel_altitude_fusion_core.sv
// Vertical altitude fusion: a third-order complementary filter that blends a barometric
// altitude with an earth-frame vertical acceleration. Each sample beat yields one estimate
// beat with the fused altitude, speed and acceleration, all signed Q24.8; gains are unsigned
// Q0.16 and the step is period_ms/1000 s. Every sum saturates and every scaled term rounds
// to nearest, ties away from zero. One sample is processed at a time: five scalings run in
// turn through one multiply pair and one radix-4 divider. The estimate sits in an output
// register, so the next sample is taken while an earlier estimate still waits. The user
// must write configuration only while idle; the block itself does not enforce this.
module baro_accel_altitude_fusion_core #(
	parameter int DATA_WIDTH = bafc_pkg::DATA_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [bafc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bafc_pkg::CFG_DATA_W-1:0]  cfg_data,
	bafc_chan_if.sink                        sample,
	bafc_chan_if.source                      estimate
);

	bafc_pkg::cmd_t    cmd;
	bafc_pkg::status_t stat;

	bafc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (estimate.valid),
		.out_ready (estimate.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	bafc_dp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.stat          (stat),
		.sample_data   (sample.payload),
		.estimate_data (estimate.payload)
	);

endmodule
